>>> design/sdlms_pkg.sv
// shared constants and types for the scrolling dual led matrix scanner
// used by sdlms_scan and scrolling_dual_led_matrix_scanner, no dependencies
package sdlms_pkg;

    localparam int MessageDepth  = 64;
    localparam int MatrixColumns = 8;
    localparam int AddrW         = $clog2(MessageDepth);
    localparam int ColW          = $clog2(MatrixColumns);
    localparam int LenW          = 7;
    localparam int RepW          = 8;
    localparam int ByteW         = 8;
    localparam int CfgIndexW     = 2;

    localparam logic [LenW-1:0] LenMin      = LenW'(MatrixColumns);
    localparam logic [LenW-1:0] LenMax      = LenW'(MessageDepth);
    localparam logic [LenW-1:0] LenReset    = LenW'(64);
    localparam logic [RepW-1:0] RepReset    = RepW'(2);
    localparam logic [ByteW-1:0] DarkByte   = '1;

    typedef enum logic [CfgIndexW-1:0] {
        CFG_MESSAGE_LENGTH = 2'd0,
        CFG_FRAME_REPEATS  = 2'd1
    } cfg_index_t;

    typedef enum logic {
        OP_TICK  = 1'b0,
        OP_WRITE = 1'b1
    } opcode_t;

    typedef struct packed {
        logic [AddrW-1:0] left_idx;
        logic [AddrW-1:0] right_idx;
        logic [ByteW-1:0] select_now;
        logic [ByteW-1:0] select_next;
    } scan_t;

endpackage

>>> design/scrolling_dual_led_matrix_scanner.sv
// top level of the scrolling dual led matrix scanner: message store,
// config registers and result register; depends on sdlms_pkg and sdlms_scan
//
// usage:
//   s_* carries items: s_tuser is the opcode (0 scan tick, 1 store write),
//   s_tdata holds write_index and write_data for a store write.
//   m_* carries one result per item: column select, left and right bytes.
//   cfg_* writes message_length (index 0) or frame_repeats (index 1);
//   cfg_ready is always high, write only while no item is in flight.
// result: registered; it appears in the cycle after its item transfers.
// throughput: one item per cycle unless a result is pending and m_tready is low;
//   one store write port, two registered read ports: a tick and a write never contend.
// stall: the result register holds while m_tready is low, and s_tready
//   follows m_tready whenever a result is pending, so items wait upstream.
// reset: scan state clears, the whole message store reads as dark (all ones)
//   through per-entry valid bits, message_length is 64, frame_repeats is 2.
//   No clearing pass is needed; items are taken right after reset.
module scrolling_dual_led_matrix_scanner (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // write_index[5:0], write_data[13:6]
    input  logic                            s_tuser,  // opcode
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [23:0]                     m_tdata,  // column_select, left, right
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [sdlms_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [7:0]                      cfg_data
);
    import sdlms_pkg::*;

    logic [LenW-1:0]  len_reg;
    logic [RepW-1:0]  rep_reg;

    logic [ByteW-1:0] mem [MessageDepth];
    logic [MessageDepth-1:0] written_reg;

    logic             out_valid_reg;
    logic             out_tick_reg;
    logic [ByteW-1:0] out_sel_reg;
    logic [ByteW-1:0] rd_left_reg;
    logic [ByteW-1:0] rd_right_reg;
    logic             vl_reg;
    logic             vr_reg;

    logic             in_xfer;
    logic             tick;
    logic             wr;
    logic [AddrW-1:0] wr_idx;
    logic [ByteW-1:0] wr_data;
    scan_t            scan;
    logic [ByteW-1:0] left_out;
    logic [ByteW-1:0] right_out;

    assign s_tready  = !out_valid_reg || m_tready;
    assign in_xfer   = s_tvalid && s_tready;
    assign tick      = in_xfer && (opcode_t'(s_tuser) == OP_TICK);
    assign wr        = in_xfer && (opcode_t'(s_tuser) == OP_WRITE);
    assign wr_idx    = s_tdata[AddrW-1:0];
    assign wr_data   = s_tdata[AddrW +: ByteW];
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg <= LenReset;
            rep_reg <= RepReset;
        end
        else if (cfg_valid)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_MESSAGE_LENGTH: len_reg <= cfg_data[LenW-1:0];
                CFG_FRAME_REPEATS:  rep_reg <= cfg_data[RepW-1:0];
                default:            ;
            endcase
        end
    end

    sdlms_scan u_scan (
        .clk            (clk),
        .rst_n          (rst_n),
        .tick           (tick),
        .message_length (len_reg),
        .frame_repeats  (rep_reg),
        .scan           (scan)
    );

    // message store and its read ports
    always_ff @(posedge clk)
    begin
        if (wr)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (tick)
        begin
            rd_left_reg  <= mem[scan.left_idx];
            rd_right_reg <= mem[scan.right_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            written_reg <= '0;
            vl_reg      <= 1'b0;
            vr_reg      <= 1'b0;
        end
        else
        begin
            if (wr)
            begin
                written_reg[wr_idx] <= 1'b1;
            end
            if (tick)
            begin
                vl_reg <= written_reg[scan.left_idx];
                vr_reg <= written_reg[scan.right_idx];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            out_tick_reg  <= 1'b0;
            out_sel_reg   <= '0;
        end
        else
        begin
            if (in_xfer)
            begin
                out_valid_reg <= 1'b1;
                out_tick_reg  <= tick;
                out_sel_reg   <= tick ? scan.select_next : scan.select_now;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign left_out  = !out_tick_reg ? '0 : (vl_reg ? rd_left_reg : DarkByte);
    assign right_out = !out_tick_reg ? '0 : (vr_reg ? rd_right_reg : DarkByte);

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {right_out, left_out, out_sel_reg};

endmodule

>>> design/sdlms_scan.sv
// scan sequencer: column, blanking, frame count and scroll offset state
// computes the two store indexes for a tick; depends on sdlms_pkg
module sdlms_scan (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       tick,
    input  logic [sdlms_pkg::LenW-1:0] message_length,
    input  logic [sdlms_pkg::RepW-1:0] frame_repeats,
    output sdlms_pkg::scan_t           scan
);
    import sdlms_pkg::*;

    logic [ColW-1:0]  col_reg, col_next;
    logic [ByteW-1:0] sel_reg, sel_next;
    logic [RepW-1:0]  frame_reg, frame_next;
    logic [AddrW-1:0] off_reg, off_next;

    logic [LenW-1:0]  len;
    logic [LenW-1:0]  off_start;
    logic [LenW-1:0]  right_sum;
    logic [LenW-1:0]  right_idx;
    logic [LenW-1:0]  left_idx;
    logic [LenW-1:0]  off_inc;
    logic [RepW-1:0]  frame_inc;

    always_comb
    begin
        if (message_length < LenMin)
        begin
            len = LenMin;
        end
        else if (message_length > LenMax)
        begin
            len = LenMax;
        end
        else
        begin
            len = message_length;
        end

        off_start = (LenW'(off_reg) >= len) ? '0 : LenW'(off_reg);
        right_sum = off_start + LenW'(col_reg);
        right_idx = (right_sum >= len) ? right_sum - len : right_sum;
        if (right_idx >= LenMin)
        begin
            left_idx = right_idx - LenMin;
        end
        else
        begin
            left_idx = right_idx + len - LenMin;
        end

        sel_next   = (sel_reg == '0) ? ByteW'(1) << col_reg : '0;
        col_next   = col_reg;
        frame_next = frame_reg;
        off_next   = AddrW'(off_start);
        frame_inc  = frame_reg + RepW'(1);
        off_inc    = off_start + LenW'(1);

        if (sel_next == '0)
        begin
            col_next = col_reg + ColW'(1);
            if (col_reg == ColW'(MatrixColumns - 1))
            begin
                frame_next = frame_inc;
                if (frame_inc == frame_repeats)
                begin
                    frame_next = '0;
                    off_next   = (off_inc >= len) ? '0 : AddrW'(off_inc);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg   <= '0;
            sel_reg   <= '0;
            frame_reg <= '0;
            off_reg   <= '0;
        end
        else if (tick)
        begin
            col_reg   <= col_next;
            sel_reg   <= sel_next;
            frame_reg <= frame_next;
            off_reg   <= off_next;
        end
    end

    assign scan.left_idx    = AddrW'(left_idx);
    assign scan.right_idx   = AddrW'(right_idx);
    assign scan.select_now  = sel_reg;
    assign scan.select_next = sel_next;

endmodule

>>> dv/sdlms_scan_checker.sv
// checker for the scrolling dual led matrix scanner: watches the item, result
// and register channels, predicts each matrix drive and compares it
// depends on sdlms_pkg only
module sdlms_scan_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    input  logic [15:0]                     s_tdata,  // write_index[5:0], write_data[13:6]
    input  logic                            s_tuser,  // opcode
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    input  logic [23:0]                     m_tdata,  // column_select, left, right
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [sdlms_pkg::CfgIndexW-1:0] cfg_index,
    input  logic [7:0]                      cfg_data,
    output int                              errors,
    output int                              pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import sdlms_pkg::*;

    typedef struct packed {
        logic [ByteW-1:0] right;
        logic [ByteW-1:0] left;
        logic [ByteW-1:0] select;
    } drive_t;

    logic [ByteW-1:0] pattern_mem [MessageDepth];
    logic [ColW-1:0]  column;
    logic [ByteW-1:0] select_reg;
    logic [RepW-1:0]  frames;
    int               offset;
    logic [LenW-1:0]  length_reg;
    logic [RepW-1:0]  repeats_reg;
    drive_t           matrix_drive_q [$];
    int               mismatches;

    function automatic int span();
        int n;
        n = int'(length_reg);
        if (n < MatrixColumns)
            n = MatrixColumns;
        if (n > MessageDepth)
            n = MessageDepth;
        return n;
    endfunction

    task automatic advance_scan(input opcode_t op, input logic [AddrW-1:0] widx,
                                input logic [ByteW-1:0] wdata, output drive_t d);
        int n;
        int r;
        int l;
        if (op == OP_WRITE)
        begin
            pattern_mem[widx] = wdata;
            d.select = select_reg;
            d.left   = '0;
            d.right  = '0;
        end
        else
        begin
            n = span();
            if (offset >= n)
                offset = 0;
            r = offset + int'(column);
            if (r >= n)
                r -= n;
            if (r >= MatrixColumns)
                l = r - MatrixColumns;
            else
                l = r + n - MatrixColumns;
            d.left  = pattern_mem[l % MessageDepth];
            d.right = pattern_mem[r % MessageDepth];
            if (select_reg == '0)
                select_reg = ByteW'(1) << column;
            else
                select_reg = '0;
            d.select = select_reg;
            if (select_reg == '0)
            begin
                column = column + 1'b1;
                if (column == '0)
                begin
                    frames = frames + 1'b1;
                    if (frames == repeats_reg)
                    begin
                        frames = '0;
                        offset += 1;
                        if (offset >= n)
                            offset = 0;
                    end
                end
            end
        end
    endtask

    task automatic check_field(input string name, input logic [ByteW-1:0] want,
                               input logic [ByteW-1:0] got);
        if (got !== want)
        begin
            $display("%0t %s mismatch: expected %02h actual %02h", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        drive_t want;
        drive_t got;
        if (!rst_n)
        begin
            foreach (pattern_mem[i])
                pattern_mem[i] = DarkByte;
            column      = '0;
            select_reg  = '0;
            frames      = '0;
            offset      = 0;
            length_reg  = LenReset;
            repeats_reg = RepReset;
            matrix_drive_q.delete();
            mismatches  = 0;
            errors     <= 0;
            pending    <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_MESSAGE_LENGTH: length_reg  = cfg_data[LenW-1:0];
                    CFG_FRAME_REPEATS:  repeats_reg = cfg_data[RepW-1:0];
                    default: ;
                endcase
            end
            if (m_tvalid && m_tready)
            begin
                got = drive_t'(m_tdata);
                if (matrix_drive_q.size() == 0)
                begin
                    $display("%0t unexpected result: expected none actual %06h", $time, m_tdata);
                    mismatches++;
                end
                else
                begin
                    want = matrix_drive_q.pop_front();
                    check_field("column_select", want.select, got.select);
                    check_field("left_pattern", want.left, got.left);
                    check_field("right_pattern", want.right, got.right);
                end
            end
            if (s_tvalid && s_tready)
            begin
                advance_scan(opcode_t'(s_tuser), s_tdata[AddrW-1:0],
                             s_tdata[AddrW+ByteW-1:AddrW], want);
                matrix_drive_q.push_back(want);
            end
            pending <= matrix_drive_q.size();
            errors  <= mismatches;
        end
    end

endmodule

>>> dv/testbench.sv
// top of the scanner testbench: clock, reset, item and register stimulus with
// random gaps and stalls; depends on sdlms_pkg, sdlms_scan_checker and the block
module testbench;
    timeunit 1ns;
    timeprecision 1ps;
    import sdlms_pkg::*;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [15:0]          s_tdata   = '0;  // write_index[5:0], write_data[13:6]
    logic                 s_tuser   = 1'b0;  // opcode
    logic                 m_tvalid;
    logic                 m_tready  = 1'b1;
    logic [23:0]          m_tdata;  // column_select, left, right
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CfgIndexW-1:0] cfg_index = '0;
    logic [7:0]           cfg_data  = '0;

    int   errors;
    int   pending;
    logic calm      = 1'b0;
    int   stall_left = 0;
    int   n_ticks   = 0;
    int   n_writes  = 0;
    int   n_cfg     = 0;

    scrolling_dual_led_matrix_scanner u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    sdlms_scan_checker u_checker (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .errors    (errors),
        .pending   (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int idle_len();
        if ($urandom_range(0, 99) < 85)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 25)
        begin
            stall_left <= idle_len() - 1;
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    task automatic write_reg(input cfg_index_t idx, input logic [7:0] value);
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        n_cfg++;
    endtask

    task automatic send_item(input opcode_t op, input logic [AddrW-1:0] idx,
                             input logic [ByteW-1:0] data);
        int gap;
        gap = (!calm && $urandom_range(0, 99) < 25) ? idle_len() : 0;
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= {2'b00, data, idx};
        do
            @(posedge clk);
        while (!s_tready);
        if (op == OP_WRITE)
            n_writes++;
        else
            n_ticks++;
    endtask

    task automatic scan_ticks(input int n);
        repeat (n) send_item(OP_TICK, AddrW'($urandom), ByteW'($urandom));
    endtask

    task automatic run_phase(input logic [7:0] len, input logic [7:0] reps, input int n);
        int top_idx;
        top_idx = int'(len[LenW-1:0]);
        if (top_idx < MatrixColumns)
            top_idx = MatrixColumns;
        if (top_idx > MessageDepth)
            top_idx = MessageDepth;
        write_reg(CFG_MESSAGE_LENGTH, len);
        write_reg(CFG_FRAME_REPEATS, reps);
        calm <= ($urandom_range(0, 3) == 0);
        repeat (n)
        begin
            if ($urandom_range(0, 9) < 3)
                send_item(OP_WRITE,
                          ($urandom_range(0, 4) == 0) ? AddrW'($urandom_range(0, 63))
                                                      : AddrW'($urandom_range(0, top_idx - 1)),
                          ByteW'($urandom_range(0, 255)));
            else
                scan_ticks(1);
        end
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // dark store at reset, then data and index extremes
        scan_ticks(3);
        send_item(OP_WRITE, 6'd0, 8'h00);
        send_item(OP_WRITE, 6'd63, 8'h80);
        send_item(OP_WRITE, 6'd1, 8'hFF);
        send_item(OP_WRITE, 6'd7, 8'h01);
        send_item(OP_WRITE, 6'd8, 8'hAA);
        send_item(OP_WRITE, 6'd56, 8'h55);
        scan_ticks(1);
        send_item(OP_WRITE, 6'd2, 8'h3C);
        scan_ticks(3);
        // shortest message and fastest scroll
        write_reg(CFG_MESSAGE_LENGTH, 8'd8);
        write_reg(CFG_FRAME_REPEATS, 8'd1);
        scan_ticks(10);

        // long run at full length, then shrink so the offset lands past the end
        run_phase(8'd64, 8'd1, 260);
        run_phase(8'd8, 8'd1, 40);
        run_phase(8'd0, 8'd3, 50);
        run_phase(8'd127, 8'd1, 40);
        run_phase(8'hC8, 8'd2, 30);
        run_phase(8'($urandom_range(8, 64)), 8'd255, 40);
        run_phase(8'($urandom_range(8, 64)), 8'd1, 30);
        run_phase(8'($urandom_range(8, 64)), 8'd0, 30);
        repeat (3)
            run_phase(8'($urandom_range(8, 64)), 8'($urandom_range(1, 4)), 30);
        calm <= 1'b0;

        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d scan ticks and %0d store writes over %0d register writes",
                 n_ticks, n_writes, n_cfg);
        $display("lengths below, at and above range, repeats 0, 1 and 255, offset past end");
        if (errors == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
